/* sv/wpd_pkg.sv */
// Shared types and constants for the window percentile depth unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wpd_pkg;

  // Field widths fixed by the interface
  localparam int POS_W     = 12;
  localparam int DEPTH_W   = 16;
  localparam int FW_W      = 11;
  localparam int FH_W      = 10;
  localparam int RAD_W     = 3;
  localparam int PCT_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int Q16_FRAC  = 16;

  localparam logic [PCT_W-1:0] Q16_ONE = 17'h10000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID    = 2'd3;

  localparam logic [DEPTH_W-1:0] MIN_VALID_RST = 16'd250;
  localparam logic [DEPTH_W-1:0] MAX_VALID_RST = 16'd6000;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // One depth sample moving along the sort chain
  typedef struct packed {
    logic               vld;
    logic [DEPTH_W-1:0] depth;
  } wpd_sample_t;

  // Gather unit output: a sample and the end-of-window mark
  typedef struct packed {
    wpd_sample_t smp;
    logic        last;
  } wpd_gath_t;

  // Sort chain control
  typedef struct packed {
    logic clear;
    logic shift;
  } wpd_cell_ctl_t;

  // Effective frame configuration
  typedef struct packed {
    logic [FW_W-1:0]    w;
    logic [FH_W-1:0]    h;
    logic [DEPTH_W-1:0] min_mm;
    logic [DEPTH_W-1:0] max_mm;
  } wpd_cfg_t;

  // Accepted input item handed to the gather unit
  typedef struct packed {
    logic               vld;
    logic               func;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [DEPTH_W-1:0] depth;
    logic [RAD_W-1:0]   radius;
  } wpd_cmd_t;

endpackage

/* sv/window_percentile_depth_unit.sv */
// Window percentile depth unit: stores a depth frame in millimetres and answers
// windowed percentile queries over it. Depends on wpd_pkg, wpd_gather, wpd_cell.
// Input channel (in_valid / in_stall): in_func 0 writes in_depth_value at
// (in_pos_x, in_pos_y), dropped if outside the frame; in_func 1 queries the
// square window of half size in_radius around that point at percentile
// in_percentile_q16 (Q16, 32768 is the median).
// Result channel (out_valid / out_stall): one item per query, none per write.
// Config port: cfg_we writes cfg_data to the register at cfg_index
// (frame width, frame height, min valid mm, max valid mm); write only when idle.
// Writes follow back to back while no query is in progress.
// A query reads its window of (2r+1)^2 pixels, r the saturated radius: one window
// pixel is read per cycle from the single frame memory port; the sort chain then
// drains its n qualifying samples and shifts toward its head to the selected rank k.
// Reset restores the register defaults and empties the sort chain; the frame
// memory is not cleared and must be written before it is queried.
// A stalled result holds in the output register; a further write is still taken,
// and the next query finishes its work then waits for the register to free up.
`timescale 1ns / 1ps

module window_percentile_depth_unit #(
  parameter int MAX_WIDTH  = 1280,
  parameter int MAX_HEIGHT = 720,
  parameter int MAX_RADIUS = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpd_pkg::DEPTH_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic signed [wpd_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [wpd_pkg::POS_W-1:0]   in_pos_y,
  input  logic [wpd_pkg::DEPTH_W-1:0]        in_depth_value,
  input  logic [wpd_pkg::RAD_W-1:0]          in_radius,
  input  logic [wpd_pkg::PCT_W-1:0]          in_percentile_q16,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [wpd_pkg::DEPTH_W-1:0]        out_depth_mm,
  output logic                               out_found
);
  import wpd_pkg::*;

  localparam int WIN_CELLS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W     = $clog2(WIN_CELLS + 1);
  localparam int IDX_W     = $clog2(WIN_CELLS);
  localparam int KP_W      = PCT_W + IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [FW_W-1:0]    frame_width_r;
  logic [FH_W-1:0]    frame_height_r;
  logic [DEPTH_W-1:0] min_valid_r;
  logic [DEPTH_W-1:0] max_valid_r;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   drn_r;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [PCT_W-1:0]   pq_r;
  logic [DEPTH_W-1:0] res_d_r;
  logic               res_found_r;
  logic               out_valid_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic               out_found_r;

  logic               in_acc, query_acc;
  logic [CNT_W-1:0]   nm1;
  logic [KP_W-1:0]    k_prod;

  wpd_cfg_t      cfg;
  wpd_cmd_t      cmd;
  wpd_gath_t     gath;
  wpd_cell_ctl_t cell_ctl;
  wpd_sample_t   link [WIN_CELLS+1];
  wpd_sample_t   held [WIN_CELLS+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= '0;
      frame_height_r <= '0;
      min_valid_r    <= MIN_VALID_RST;
      max_valid_r    <= MAX_VALID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        CFG_MIN_VALID:    min_valid_r    <= cfg_data;
        CFG_MAX_VALID:    max_valid_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Saturate frame size to the memory layout limits
  always_comb begin
    cfg.w      = (32'(frame_width_r) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : frame_width_r;
    cfg.h      = (32'(frame_height_r) > MAX_HEIGHT) ? FH_W'(MAX_HEIGHT) : frame_height_r;
    cfg.min_mm = min_valid_r;
    cfg.max_mm = max_valid_r;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign query_acc = in_acc && (in_func == FUNC_QUERY);

  assign cmd.vld    = in_acc;
  assign cmd.func   = in_func;
  assign cmd.x      = in_pos_x;
  assign cmd.y      = in_pos_y;
  assign cmd.depth  = in_depth_value;
  assign cmd.radius = in_radius;

  wpd_gather #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_gather (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .cfg   (cfg),
    .gath  (gath)
  );

  // Sort chain: samples enter at the head, larger values ripple toward the tail
  assign cell_ctl.clear = query_acc;
  assign cell_ctl.shift = (state_r == ST_SHIFT) && (k_r != '0);
  assign link[0]        = gath.smp;
  assign held[WIN_CELLS] = '0;

  for (genvar i = 0; i < WIN_CELLS; i++) begin : g_cell
    wpd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .in_smp   (link[i]),
      .nb_smp   (held[i+1]),
      .pass_smp (link[i+1]),
      .held_smp (held[i])
    );
  end

  // Rank of the requested percentile among the n samples
  always_comb begin
    n_nxt  = n_r + (gath.smp.vld ? CNT_W'(1) : CNT_W'(0));
    nm1    = n_r - CNT_W'(1);
    k_prod = KP_W'(pq_r) * KP_W'(nm1[IDX_W-1:0]);
    k_nxt  = k_prod[Q16_FRAC +: IDX_W];
  end

  // Query sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop a taken result unless the done state loads the next one
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (query_acc) begin
            state_r <= ST_SCAN;
            n_r     <= '0;
            pq_r    <= (in_percentile_q16 > Q16_ONE) ? Q16_ONE : in_percentile_q16;
          end
        end
        ST_SCAN: begin
          n_r <= n_nxt;
          if (gath.last) begin
            if (n_nxt == '0) begin
              res_d_r     <= '0;
              res_found_r <= 1'b0;
              state_r     <= ST_DONE;
            end else begin
              drn_r   <= n_nxt;
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          k_r   <= k_nxt;
          drn_r <= drn_r - CNT_W'(1);
          if (drn_r == '0) begin
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (k_r == '0) begin
            res_d_r     <= held[0].depth;
            res_found_r <= 1'b1;
            state_r     <= ST_DONE;
          end else begin
            k_r <= k_r - IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_depth_r <= res_d_r;
            out_found_r <= res_found_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_depth_mm = out_depth_r;
  assign out_found    = out_found_r;

  // The chain is as long as the window, so nothing may fall off its tail
  a_no_chain_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !link[WIN_CELLS].vld)
    else $error("sample passed beyond the last sort cell");

  // Samples arrive only while a window is being scanned
  a_sample_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    gath.smp.vld |-> (state_r == ST_SCAN))
    else $error("sample outside of a window scan");

  // The selected head cell holds a sample when a found result is taken
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SHIFT) && (k_r == '0)) |-> held[0].vld)
    else $error("sort chain head empty at selection");

  // A query starts a fresh scan with an empty count
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> ((state_r == ST_SCAN) && (n_r == '0)))
    else $error("query did not start a new scan");

  // Sample count stays within the window size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(WIN_CELLS))
    else $error("sample count exceeds window size");

endmodule

/* sv/wpd_cell.sv */
// One cell of the insertion sort chain: keeps the smaller sample, passes the larger.
// Depends on wpd_pkg.
`timescale 1ns / 1ps

module wpd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wpd_pkg::wpd_cell_ctl_t ctl,
  input  wpd_pkg::wpd_sample_t in_smp,
  input  wpd_pkg::wpd_sample_t nb_smp,
  output wpd_pkg::wpd_sample_t pass_smp,
  output wpd_pkg::wpd_sample_t held_smp
);
  import wpd_pkg::*;

  logic               held_vld_r, held_vld_nxt;
  logic [DEPTH_W-1:0] held_d_r, held_d_nxt;
  logic               pass_vld_r, pass_vld_nxt;
  logic [DEPTH_W-1:0] pass_d_r, pass_d_nxt;

  // Insert, shift toward the head, or clear
  always_comb begin
    held_vld_nxt = held_vld_r;
    held_d_nxt   = held_d_r;
    pass_vld_nxt = 1'b0;
    pass_d_nxt   = pass_d_r;
    if (ctl.clear) begin
      held_vld_nxt = 1'b0;
    end else if (ctl.shift) begin
      held_vld_nxt = nb_smp.vld;
      held_d_nxt   = nb_smp.depth;
    end else if (in_smp.vld) begin
      if (!held_vld_r) begin
        held_vld_nxt = 1'b1;
        held_d_nxt   = in_smp.depth;
      end else if (in_smp.depth < held_d_r) begin
        held_d_nxt   = in_smp.depth;
        pass_vld_nxt = 1'b1;
        pass_d_nxt   = held_d_r;
      end else begin
        pass_vld_nxt = 1'b1;
        pass_d_nxt   = in_smp.depth;
      end
    end
  end

  // Hold valid flags under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
      pass_vld_r <= 1'b0;
    end else begin
      held_vld_r <= held_vld_nxt;
      pass_vld_r <= pass_vld_nxt;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    held_d_r <= held_d_nxt;
    pass_d_r <= pass_d_nxt;
  end

  assign pass_smp.vld   = pass_vld_r;
  assign pass_smp.depth = pass_d_r;
  assign held_smp.vld   = held_vld_r;
  assign held_smp.depth = held_d_r;

endmodule

/* sv/wpd_gather.sv */
// Window scanner, frame address pipeline, depth frame memory and sample range filter.
// Depends on wpd_pkg.
`timescale 1ns / 1ps

module wpd_gather #(
  parameter int MAX_WIDTH  = 1280,
  parameter int MAX_HEIGHT = 720,
  parameter int MAX_RADIUS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wpd_pkg::wpd_cmd_t cmd,
  input  wpd_pkg::wpd_cfg_t cfg,
  output wpd_pkg::wpd_gath_t gath
);
  import wpd_pkg::*;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int R_W       = $clog2(MAX_RADIUS + 1);
  localparam int SIDE      = 2 * MAX_RADIUS + 1;
  localparam int SI_W      = $clog2(SIDE);
  localparam int PW        = POS_W + 1;
  localparam int PROD_W    = FH_W + FW_W;

  // Scanner state
  logic                 scan_act_r, scan_act_nxt;
  logic signed [PW-1:0] cx_r, cx_nxt;
  logic signed [PW-1:0] cy_r, cy_nxt;
  logic [SI_W-1:0]      smax_r, smax_nxt;
  logic [SI_W-1:0]      ix_r, ix_nxt;
  logic [SI_W-1:0]      iy_r, iy_nxt;

  // Issued position
  logic                 is_vld, is_wr, is_last, is_hit;
  logic signed [PW-1:0] u, v;
  logic signed [PW-1:0] x_ext, y_ext, r_ext;
  logic [R_W-1:0]       r_sat;
  logic [FH_W-1:0]      v_lo;

  // Stage 1: in-frame check and row product
  logic               s1_vld_r, s1_wr_r, s1_last_r, s1_hit_r;
  logic [FW_W-1:0]    s1_u_r;
  logic [PROD_W-1:0]  s1_prod_r;
  logic [DEPTH_W-1:0] s1_d_r;

  // Stage 2: memory access
  logic [ADDR_W-1:0]  addr;
  logic [DEPTH_W-1:0] depth_mem [MEM_DEPTH];
  logic [DEPTH_W-1:0] rd_d_r;
  logic               s2_rd_r, s2_hit_r, s2_last_r;

  // Stage 3: filtered sample
  logic               g_vld_r, g_last_r;
  logic [DEPTH_W-1:0] g_d_r;

  // Pick the next position: window scan, or a single pixel write
  always_comb begin
    r_sat = (32'(cmd.radius) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(cmd.radius);
    r_ext = PW'(r_sat);
    x_ext = PW'($signed(cmd.x));
    y_ext = PW'($signed(cmd.y));

    scan_act_nxt = scan_act_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    smax_nxt     = smax_r;
    ix_nxt       = ix_r;
    iy_nxt       = iy_r;
    is_vld       = 1'b0;
    is_wr        = 1'b0;
    is_last      = 1'b0;
    u            = x_ext;
    v            = y_ext;

    if (scan_act_r) begin
      u       = cx_r + PW'(ix_r);
      v       = cy_r + PW'(iy_r);
      is_vld  = 1'b1;
      is_last = (ix_r == smax_r) && (iy_r == smax_r);
      if (ix_r == smax_r) begin
        ix_nxt = '0;
        iy_nxt = iy_r + SI_W'(1);
      end else begin
        ix_nxt = ix_r + SI_W'(1);
      end
      if (is_last) begin
        scan_act_nxt = 1'b0;
      end
    end else if (cmd.vld) begin
      if (cmd.func == FUNC_WRITE) begin
        is_vld = 1'b1;
        is_wr  = 1'b1;
      end else begin
        scan_act_nxt = 1'b1;
        cx_nxt       = x_ext - r_ext;
        cy_nxt       = y_ext - r_ext;
        smax_nxt     = SI_W'({r_sat, 1'b0});
        ix_nxt       = '0;
        iy_nxt       = '0;
      end
    end

    is_hit = !u[PW-1] && !v[PW-1] &&
             ($unsigned(POS_W'(u)) < POS_W'(cfg.w)) &&
             ($unsigned(POS_W'(v)) < POS_W'(cfg.h));
    v_lo   = FH_W'(v);
  end

  assign addr = ADDR_W'(s1_prod_r) + ADDR_W'(s1_u_r);

  // Hold control flags under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_rd_r    <= 1'b0;
      g_vld_r    <= 1'b0;
      g_last_r   <= 1'b0;
    end else begin
      scan_act_r <= scan_act_nxt;
      s1_vld_r   <= is_vld;
      s2_rd_r    <= s1_vld_r && !s1_wr_r;
      g_vld_r    <= s2_rd_r && s2_hit_r &&
                    (rd_d_r >= cfg.min_mm) && (rd_d_r <= cfg.max_mm);
      g_last_r   <= s2_rd_r && s2_last_r;
    end
  end

  // Advance scanner and pipeline payload
  always_ff @(posedge clk) begin
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    smax_r    <= smax_nxt;
    ix_r      <= ix_nxt;
    iy_r      <= iy_nxt;
    s1_wr_r   <= is_wr;
    s1_last_r <= is_last;
    s1_hit_r  <= is_hit;
    s1_u_r    <= FW_W'(u);
    s1_prod_r <= PROD_W'(v_lo) * PROD_W'(cfg.w);
    s1_d_r    <= cmd.depth;
    s2_hit_r  <= s1_hit_r;
    s2_last_r <= s1_last_r;
    g_d_r     <= rd_d_r;
  end

  // Depth frame memory: an in-frame write and the registered read share one address
  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_wr_r && s1_hit_r) begin
      depth_mem[addr] <= s1_d_r;
    end
    rd_d_r <= depth_mem[addr];
  end

  assign gath.smp.vld   = g_vld_r;
  assign gath.smp.depth = g_d_r;
  assign gath.last      = g_last_r;

endmodule
